/* design/kdp_pkg.sv */
// Package for the 0/1 knapsack row engine: field widths, limits, payload
// structs and the control structs passed between the engine's modules.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps

package kdp_pkg;

  localparam int unsigned CAP_MAX_DEFAULT = 64;
  localparam int unsigned CAP_W           = 7;
  localparam int unsigned WT_W            = 8;
  localparam int unsigned ITEM_VAL_W      = 16;
  localparam int unsigned VAL_W           = 24;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(64);
  localparam logic [VAL_W-1:0] VAL_LIMIT      = {VAL_W{1'b1}};

  typedef struct packed {
    logic [WT_W-1:0]       item_weight;
    logic [ITEM_VAL_W-1:0] item_value;
    logic                  first_item;
  } kdp_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] best_value;
    logic             saturated;
  } kdp_result_t;

  // One row step in flight between the read and the update stage.
  typedef struct packed {
    logic valid;
    logic fit;
    logic exact;
    logic first;
  } kdp_step_t;

  // What the update stage decided for that step.
  typedef struct packed {
    logic write;
    logic sat_hit;
  } kdp_upd_t;

endpackage

/* design/kdp_row_mem.sv */
// Row memory of the knapsack engine: one write port, two read ports with
// registered read data. Depends on kdp_pkg for the entry width.
`timescale 1ns / 1ps

module kdp_row_mem #(
  parameter int unsigned DEPTH = kdp_pkg::CAP_MAX_DEFAULT,
  parameter int unsigned AW    = 6
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [kdp_pkg::VAL_W-1:0] wdata,
  input  logic [AW-1:0]            ra_addr,
  input  logic [AW-1:0]            rb_addr,
  output logic [kdp_pkg::VAL_W-1:0] ra_data,
  output logic [kdp_pkg::VAL_W-1:0] rb_data
);
  import kdp_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

/* design/kdp_update.sv */
// Update stage of the knapsack engine: saturating candidate sum, compare
// against the kept entry and write decision. Depends on kdp_pkg.
`timescale 1ns / 1ps

module kdp_update (
  input  kdp_pkg::kdp_step_t             step,
  input  logic [kdp_pkg::ITEM_VAL_W-1:0] item_value,
  input  logic [kdp_pkg::VAL_W-1:0]      old_data,
  input  logic [kdp_pkg::VAL_W-1:0]      base_data,
  output logic [kdp_pkg::VAL_W-1:0]      new_val,
  output kdp_pkg::kdp_upd_t              upd
);
  import kdp_pkg::*;

  logic [VAL_W-1:0] base_sel;
  logic [VAL_W:0]   cand;
  logic [VAL_W-1:0] cand_c;
  logic             over;
  logic             take;

  // An exact fit takes the object's value alone.
  assign base_sel = step.exact ? '0 : base_data;
  assign cand     = {1'b0, base_sel} + (VAL_W+1)'(item_value);
  assign over     = cand >= {1'b0, VAL_LIMIT};
  assign cand_c   = over ? VAL_LIMIT : cand[VAL_W-1:0];
  assign take     = step.fit && (cand_c > old_data);
  assign new_val  = take ? cand_c : old_data;

  assign upd.write   = step.valid && take;
  assign upd.sat_hit = step.valid && step.fit && over;

endmodule

/* design/knapsack_01_dp_row_update_top.sv */
// Top level of the 0/1 knapsack row engine: sequencer, clearing sweep and
// output register. Depends on kdp_pkg, kdp_row_mem and kdp_update.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                    Payload
//  item      in         item_valid / item_stall      kdp_item_t   (one object)
//  result    out        result_valid / result_stall  kdp_result_t (best value)
//  cfg       in         cfg_we                       cfg_wdata    (capacity)
//
// A request without first_item is walked from the effective capacity down
// to one, then passes the finish and hold states before its result is
// loaded: the walk issues one row entry per cycle through the two read ports
// of the row memory. A request with first_item first runs the clearing sweep.
// After reset the same sweep clears the row; no request is accepted meanwhile,
// while configuration writes are taken as ever.
// The result sits in its own register, so a stalled result does not stop the
// next request from being accepted and walked. That next request then waits
// with the request stall high until the earlier result has been taken.

module knapsack_01_dp_row_update_top #(
  parameter int unsigned CAP_MAX = kdp_pkg::CAP_MAX_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  kdp_pkg::kdp_item_t         item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output kdp_pkg::kdp_result_t       result,
  input  logic                       cfg_we,
  input  logic [kdp_pkg::CAP_W-1:0]  cfg_wdata
);
  import kdp_pkg::*;

  // AW addresses the row, CW holds a capacity up to CAP_MAX, and KW is wide
  // enough to compare a capacity with an object's weight.
  localparam int unsigned AW = (CAP_MAX > 1) ? $clog2(CAP_MAX) : 1;
  localparam int unsigned CW = $clog2(CAP_MAX + 1);
  localparam int unsigned KW = (CW > WT_W) ? CW : WT_W;
  localparam int unsigned XW = (KW > CAP_W) ? KW : CAP_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FIN,
    ST_HOLD
  } state_t;

  state_t            state;
  logic [CAP_W-1:0]  capacity;
  logic [CW-1:0]     cap_q;
  logic [CW-1:0]     walk_c;
  logic [AW-1:0]     clr_addr;
  logic              clr_walk;
  logic [WT_W-1:0]   wt_q;
  logic [ITEM_VAL_W-1:0] val_q;
  logic [VAL_W-1:0]  res_q;
  logic              sat_seen;
  kdp_step_t         s1;
  logic [AW-1:0]     s1_addr;

  logic [CW-1:0]     eff_cap;
  logic [XW-1:0]     cap_x;
  logic              issue;
  logic [CW-1:0]     c_m1;
  logic [KW-1:0]     c_k;
  logic [KW-1:0]     wt_k;
  logic [KW-1:0]     base_diff;
  logic [AW-1:0]     ra_addr;
  logic [AW-1:0]     rb_addr;
  logic [VAL_W-1:0]  old_data;
  logic [VAL_W-1:0]  base_data;
  logic [VAL_W-1:0]  new_val;
  kdp_upd_t          upd;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [VAL_W-1:0]  mem_wdata;

  // A capacity of zero acts as one; a capacity above the table acts as the
  // table depth.
  assign cap_x = XW'(capacity);
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (cap_x > XW'(CAP_MAX)) begin
      eff_cap = CW'(CAP_MAX);
    end else begin
      eff_cap = CW'(cap_x);
    end
  end

  assign item_stall = (state != ST_IDLE);

  // The walk runs from the effective capacity down to one. Both reads of a
  // step address entries below the one written by the step before it, so
  // no forwarding is needed inside a walk.
  assign issue     = (state == ST_WALK);
  assign c_m1      = walk_c - CW'(1);
  assign ra_addr   = c_m1[AW-1:0];
  assign c_k       = KW'(walk_c);
  assign wt_k      = KW'(wt_q);
  assign base_diff = c_k - wt_k - KW'(1);
  assign rb_addr   = (c_k > wt_k) ? base_diff[AW-1:0] : '0;

  // The clearing sweep owns the write port while it runs.
  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = upd.write;
      mem_waddr = s1_addr;
      mem_wdata = new_val;
    end
  end

  kdp_row_mem #(
    .DEPTH (CAP_MAX),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (old_data),
    .rb_data (base_data)
  );

  kdp_update u_upd (
    .step       (s1),
    .item_value (val_q),
    .old_data   (old_data),
    .base_data  (base_data),
    .new_val    (new_val),
    .upd        (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      capacity     <= CAPACITY_RESET;
      clr_addr     <= '0;
      clr_walk     <= 1'b0;
      sat_seen     <= 1'b0;
      s1.valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end

      // Read stage to update stage.
      s1.valid <= issue;
      s1.fit   <= c_k >= wt_k;
      s1.exact <= c_k == wt_k;
      s1.first <= walk_c == cap_q;
      s1_addr  <= ra_addr;

      // The first step of a walk touches the entry at full capacity, which
      // is the best value returned for this object.
      if (s1.valid) begin
        if (upd.sat_hit) begin
          sat_seen <= 1'b1;
        end
        if (s1.first) begin
          res_q <= new_val;
        end
      end

      // The hold state handles its own output register.
      if (result_valid && !result_stall && (state != ST_HOLD)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == AW'(CAP_MAX - 1)) begin
            clr_addr <= '0;
            clr_walk <= 1'b0;
            state    <= clr_walk ? ST_WALK : ST_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (item_valid) begin
            wt_q   <= item.item_weight;
            val_q  <= item.item_value;
            cap_q  <= eff_cap;
            walk_c <= eff_cap;
            if (item.first_item) begin
              sat_seen <= 1'b0;
              clr_walk <= 1'b1;
              state    <= ST_CLEAR;
            end else begin
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          walk_c <= c_m1;
          if (walk_c == CW'(1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= ST_HOLD;
        end
        ST_HOLD: begin
          if (!result_valid || !result_stall) begin
            result_valid      <= 1'b1;
            result.best_value <= res_q;
            result.saturated  <= sat_seen;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Nothing may write the row while the engine waits for a request.
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_we)
    else $error("row written while idle");

  // A new result is only ever loaded from the hold state.
  a_result_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_HOLD))
    else $error("result loaded outside the hold state");

  // The saturation flag only drops when a first object is accepted.
  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    (sat_seen && !(item_valid && !item_stall && item.first_item)) |=> sat_seen)
    else $error("saturation flag dropped");

  // The walk counter stays within the latched capacity.
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (walk_c >= CW'(1) && walk_c <= cap_q))
    else $error("walk counter out of range");
`endif

endmodule
